[hw/rtl/html_escape_with_charset_check_macros.svh]
// ============================================================================
// HTML escaper assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef HTML_ESCAPE_WITH_CHARSET_CHECK_MACROS_SVH
`define HTML_ESCAPE_WITH_CHARSET_CHECK_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define HEC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define HEC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hec_pkg.sv]
// ============================================================================
// HTML escaper package
// Types, constants and byte classification shared by the escaper modules.
// ============================================================================
package hec_pkg;

    localparam int CAP_W       = 16;
    localparam int WORK_DEPTH  = 4;
    localparam int SEQ_DEPTH   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_ESC  = 2'd1;
    localparam logic [1:0] CFG_CAP  = 2'd2;

    localparam logic [7:0] QMARK        = 8'h3F;
    localparam logic [7:0] DEL          = 8'h7F;
    localparam logic [7:0] EURO         = 8'h80;
    localparam logic [7:0] GBK_LEAD_MAX = 8'hFE;
    localparam logic [7:0] TRAIL_MIN    = 8'h40;
    localparam logic [4:0] UTF8_LEAD4   = 5'h1E;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_UTF8 = 2'd1,
        MODE_GBK  = 2'd2,
        MODE_OFF  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        CLS_DROP,
        CLS_PLAIN,
        CLS_QUOT,
        CLS_AMP,
        CLS_APOS,
        CLS_LT,
        CLS_GT,
        CLS_SPACE,
        CLS_NL,
        CLS_HIGH
    } t_cls;

    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
        logic       end_mark;
    } t_item;

    typedef struct packed {
        logic       act;
        logic [2:0] wn;
        logic       ovf;
        logic [2:0] seq_n;
    } t_back_stat;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c = CLS_PLAIN;
        if (b[7]) begin
            c = CLS_HIGH;
        end else begin
            unique case (b)
                8'h22: c = CLS_QUOT;
                8'h26: c = CLS_AMP;
                8'h27: c = CLS_APOS;
                8'h3C: c = CLS_LT;
                8'h3E: c = CLS_GT;
                8'h09, 8'h20: c = CLS_SPACE;
                8'h0A: c = CLS_NL;
                default: c = (b < 8'h20) ? CLS_DROP : CLS_PLAIN;
            endcase
        end
        return c;
    endfunction

    // Number of output bytes for a byte below the high range.
    function automatic logic [2:0] char_len(input t_cls c, input logic esc);
        logic [2:0] n;
        n = 3'd1;
        unique case (c)
            CLS_DROP:          n = 3'd0;
            CLS_QUOT:          n = 3'd6;
            CLS_AMP, CLS_APOS: n = 3'd5;
            CLS_LT, CLS_GT:    n = 3'd4;
            CLS_SPACE, CLS_NL: n = esc ? 3'd6 : 3'd1;
            default:           n = 3'd1;
        endcase
        return n;
    endfunction

    // Output text, first byte in the top bits.
    function automatic logic [47:0] char_text(input logic [7:0] b, input t_cls c,
                                             input logic esc);
        logic [47:0] t;
        t = {b, 40'h0};
        unique case (c)
            CLS_QUOT:  t = "&quot;";
            CLS_AMP:   t = {"&amp;", 8'h00};
            CLS_APOS:  t = {"&#39;", 8'h00};
            CLS_LT:    t = {"&lt;", 16'h0000};
            CLS_GT:    t = {"&gt;", 16'h0000};
            CLS_SPACE: t = esc ? "&nbsp;" : {b, 40'h0};
            CLS_NL:    t = esc ? "<br />" : {b, 40'h0};
            default:   t = {b, 40'h0};
        endcase
        return t;
    endfunction

    function automatic logic is_trail(input t_mode mode, input logic [7:0] b);
        if (mode == MODE_UTF8) begin
            return b[7:6] == 2'b10;
        end
        return (b != DEL) && (b >= TRAIL_MIN) && (b <= GBK_LEAD_MAX);
    endfunction

    // Continuation bytes that a UTF-8 lead asks for, zero when it is no lead.
    function automatic logic [1:0] utf8_need(input logic [7:0] h);
        logic [1:0] n;
        n = 2'd0;
        if (h[7:5] == 3'b110) begin
            n = 2'd1;
        end else if (h[7:4] == 4'hE) begin
            n = 2'd2;
        end else if (h[7:3] == UTF8_LEAD4) begin
            n = 2'd3;
        end
        return n;
    endfunction

endpackage

[hw/rtl/hec_front.sv]
// ============================================================================
// HTML escaper front end
// Accepts source items, classifies the byte and pushes them into the queue.
// ============================================================================
module hec_front import hec_pkg::*; (
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_mark,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_item.data     = i_data_byte;
        o_item.cls      = classify(i_data_byte);
        o_item.end_mark = i_end_mark;
    end

endmodule

[hw/rtl/hec_queue.sv]
// ============================================================================
// HTML escaper item queue
// Short FIFO of classified items between the front and back ends.
// ============================================================================
module hec_queue import hec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_head,
    input  logic  i_pop
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

[hw/rtl/hec_back.sv]
// ============================================================================
// HTML escaper back end
// Resolves bytes against the pending lookahead, checks capacity and emits the
// escaped output one byte per cycle, while not stalled, through an output register.
// ============================================================================
module hec_back import hec_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mode            i_mode,
    input  logic             i_esc,
    input  logic [CAP_W-1:0] i_cap,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_final_res,
    output logic             o_status,
    output t_back_stat       o_stat
);

    // Work buffer: pending lookahead plus the byte of the current item.
    logic [7:0]       r_wb [WORK_DEPTH];
    t_cls             r_wc [WORK_DEPTH];
    logic [2:0]       r_wn;
    logic             r_act;
    logic             r_wend;
    logic [CAP_W-1:0] r_emit;
    logic             r_ovf;
    // Remaining bytes of an entity or multi-byte sequence.
    logic [7:0]       r_seq [SEQ_DEPTH];
    logic [2:0]       r_seq_n;
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_of;
    logic             r_os;

    logic [7:0]       n_wb [WORK_DEPTH];
    t_cls             n_wc [WORK_DEPTH];
    logic [2:0]       n_wn;
    logic             n_act;
    logic             n_wend;
    logic [CAP_W-1:0] n_emit;
    logic             n_ovf;
    logic [7:0]       n_seq [SEQ_DEPTH];
    logic [2:0]       n_seq_n;
    logic             n_ov;
    logic [7:0]       n_ob;
    logic             n_of;
    logic             n_os;

    logic [7:0]       v_b [WORK_DEPTH];
    t_cls             v_c [WORK_DEPTH];
    logic [2:0]       v_n;
    logic             v_end;

    logic [1:0]       need;
    logic [2:0]       avail;
    logic             chain_ok;
    logic             complete;
    logic             wait_flag;
    logic [2:0]       e_len;
    logic [47:0]      e_text;
    logic [2:0]       k;
    logic [CAP_W:0]   sum;
    logic             cap_fail;
    logic             out_free;
    logic [2:0]       idx;

    always_comb begin
        v_b   = r_wb;
        v_c   = r_wc;
        v_n   = r_wn;
        v_end = r_wend;
        if (!r_act) begin
            v_end = i_q_item.end_mark;
            if (r_ovf || i_mode == MODE_OFF) begin
                v_n = '0;
            end else if (!i_q_item.end_mark) begin
                v_b[r_wn[1:0]] = i_q_item.data;
                v_c[r_wn[1:0]] = i_q_item.cls;
                v_n            = r_wn + 3'd1;
            end
        end
    end

    always_comb begin
        need      = '0;
        chain_ok  = 1'b1;
        complete  = 1'b0;
        wait_flag = 1'b0;
        e_len     = '0;
        e_text    = '0;
        k         = '0;
        avail     = v_n - 3'd1;
        if (v_c[0] != CLS_HIGH) begin
            e_len  = char_len(v_c[0], i_esc);
            e_text = char_text(v_b[0], v_c[0], i_esc);
            k      = 3'd1;
        end else if (i_mode == MODE_RAW || (i_mode == MODE_GBK && v_b[0] == EURO)) begin
            e_len  = 3'd1;
            e_text = {v_b[0], 40'h0};
            k      = 3'd1;
        end else begin
            if (i_mode == MODE_UTF8) begin
                need = utf8_need(v_b[0]);
            end else if (i_mode == MODE_GBK && v_b[0] <= GBK_LEAD_MAX) begin
                need = 2'd1;
            end
            for (int i = 1; i < WORK_DEPTH; i++) begin
                if (3'(i) <= {1'b0, need} && 3'(i) <= avail
                        && !is_trail(i_mode, v_b[i])) begin
                    chain_ok = 1'b0;
                end
            end
            complete = avail >= {1'b0, need};
            if (need != 2'd0 && chain_ok && complete) begin
                e_len  = {1'b0, need} + 3'd1;
                e_text = {v_b[0], v_b[1], v_b[2], v_b[3], 16'h0000};
                k      = {1'b0, need} + 3'd1;
            end else if (need != 2'd0 && chain_ok && !v_end) begin
                // Lead still short of continuation bytes: it waits.
                wait_flag = 1'b1;
                e_len     = 3'd1;
            end else begin
                e_len  = 3'd1;
                e_text = {QMARK, 40'h0};
                k      = 3'd1;
            end
        end
        // A dropped byte needs no room, whatever the count and the limit.
        sum      = {1'b0, r_emit} + (CAP_W + 1)'(e_len);
        cap_fail = (e_len != 3'd0) && (sum > {1'b0, i_cap});
    end

    always_comb begin
        n_wb     = r_wb;
        n_wc     = r_wc;
        n_wn     = r_wn;
        n_act    = r_act;
        n_wend   = r_wend;
        n_emit   = r_emit;
        n_ovf    = r_ovf;
        n_seq    = r_seq;
        n_seq_n  = r_seq_n;
        n_ov     = r_ov && !i_out_ready;
        n_ob     = r_ob;
        n_of     = r_of;
        n_os     = r_os;
        idx      = '0;
        o_q_pop  = 1'b0;
        out_free = !r_ov || i_out_ready;
        if (out_free) begin
            if (r_seq_n != 3'd0) begin
                n_ov = 1'b1;
                n_ob = r_seq[0];
                n_of = 1'b0;
                n_os = 1'b0;
                for (int i = 0; i < SEQ_DEPTH - 1; i++) begin
                    n_seq[i] = r_seq[i+1];
                end
                n_seq_n = r_seq_n - 3'd1;
            end else if (r_act || i_q_valid) begin
                o_q_pop = !r_act;
                if (v_n == 3'd0) begin
                    n_act = 1'b0;
                    n_wn  = '0;
                    if (v_end) begin
                        n_ov   = 1'b1;
                        n_ob   = '0;
                        n_of   = 1'b1;
                        n_os   = r_ovf;
                        n_emit = '0;
                        n_ovf  = 1'b0;
                    end
                end else if (cap_fail) begin
                    n_ovf  = 1'b1;
                    n_wn   = '0;
                    n_act  = v_end;
                    n_wend = v_end;
                end else if (wait_flag) begin
                    n_act = 1'b0;
                    n_wb  = v_b;
                    n_wc  = v_c;
                    n_wn  = v_n;
                end else begin
                    if (e_len != 3'd0) begin
                        n_ov = 1'b1;
                        n_ob = e_text[47:40];
                        n_of = 1'b0;
                        n_os = 1'b0;
                        for (int i = 0; i < SEQ_DEPTH; i++) begin
                            n_seq[i] = e_text[39-8*i -: 8];
                        end
                        n_seq_n = e_len - 3'd1;
                        n_emit  = sum[CAP_W-1:0];
                    end
                    for (int i = 0; i < WORK_DEPTH; i++) begin
                        idx = 3'(i) + k;
                        n_wb[i] = (idx < 3'(WORK_DEPTH)) ? v_b[idx[1:0]] : v_b[i];
                        n_wc[i] = (idx < 3'(WORK_DEPTH)) ? v_c[idx[1:0]] : v_c[i];
                    end
                    n_wn   = v_n - k;
                    n_act  = (v_n != k) || v_end;
                    n_wend = v_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb  <= n_wb;
        r_wc  <= n_wc;
        r_seq <= n_seq;
        r_ob  <= n_ob;
        r_of  <= n_of;
        r_os  <= n_os;
        if (!i_rst_n) begin
            r_wn    <= '0;
            r_act   <= 1'b0;
            r_wend  <= 1'b0;
            r_emit  <= '0;
            r_ovf   <= 1'b0;
            r_seq_n <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_wn    <= n_wn;
            r_act   <= n_act;
            r_wend  <= n_wend;
            r_emit  <= n_emit;
            r_ovf   <= n_ovf;
            r_seq_n <= n_seq_n;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_byte   = r_ob;
    assign o_final_res  = r_of;
    assign o_status     = r_os;
    assign o_stat.act   = r_act;
    assign o_stat.wn    = r_wn;
    assign o_stat.ovf   = r_ovf;
    assign o_stat.seq_n = r_seq_n;

endmodule

[hw/rtl/html_escape_with_charset_check.sv]
// ============================================================================
// HTML escaper with character-set check
// Turns a text byte stream into an HTML-escaped byte stream. Each input item
// is one source byte or an end mark. The five markup characters become
// entities, control bytes other than tab, newline and space are dropped, and
// with escape_whitespace set tab and space become &nbsp; and newline <br />.
// High bytes are copied raw, checked as UTF-8 or checked as GBK pairs, as
// charset_mode selects; an invalid lead is replaced by '?'. Up to three bytes
// of an unfinished sequence wait in the back end for the next items. Once
// out_capacity would be exceeded nothing more is emitted for the string. An
// end item flushes the waiting bytes and produces a terminator item with a
// zero byte, final_res set and the overflow status. The front end classifies
// each item and places it in a four-entry queue; the back end drains the
// queue and drives one output register, so it sends at most one result item
// per cycle. In every cycle in which the output register is free, the back
// end either sends the next byte of an entity or sequence already begun, or
// resolves the oldest byte that it holds and sends the first byte of its
// output. Plain text therefore streams at one item per cycle while the
// result channel does not stall; the bytes of an entity or of a complete
// multi-byte sequence are all sent before the next byte is resolved. A
// dropped byte, a lead left waiting, a byte that meets the capacity limit and
// any data byte after the limit was met produce no result. Bytes that waited
// are resolved again, in their order, when a later item decides them. An end
// item sends its terminator after any waiting bytes that it flushes. While
// the result channel stalls the back end holds, and once the four-entry queue
// is full the front end lowers o_in_ready. Configuration writes take effect
// at the next clock edge.
// ============================================================================
`include "html_escape_with_charset_check_macros.svh"

module html_escape_with_charset_check import hec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Source item channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_mark,
    // Result item channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_final_res,
    output logic        o_status
);

    // Configuration registers.
    t_mode            r_mode;
    logic             r_esc;
    logic [CAP_W-1:0] r_cap;

    // Front to queue, queue to back.
    logic       q_push;
    t_item      push_item;
    logic       q_full;
    logic       q_valid;
    t_item      q_head;
    logic       q_pop;
    t_back_stat stat;

    // Writes to the unused index are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RAW;
            r_esc  <= 1'b1;
            r_cap  <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_ESC:  r_esc  <= i_cfg_data[0];
                CFG_CAP:  r_cap  <= i_cfg_data[CAP_W-1:0];
                default:  r_cap  <= r_cap;
            endcase
        end
    end

    // The front end only classifies; all decisions that depend on the
    // configuration are taken in the back end when a byte is resolved.
    hec_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_end_mark  (i_end_mark),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_item      (push_item)
    );

    hec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // The back end holds the pending lookahead, the emitted count and the
    // overflow flag, and sequences entities and multi-byte copies through
    // its output register.
    hec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_esc       (r_esc),
        .i_cap       (r_cap),
        .i_q_valid   (q_valid),
        .i_q_item    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_final_res (o_final_res),
        .o_status    (o_status),
        .o_stat      (stat)
    );

    // Between items at most three bytes of an unfinished sequence wait.
    `HEC_ASSERT_IMPL(a_pending_limit, !stat.act, stat.wn <= 3'd3, "pending bytes above three")

    // The back end only takes an item from a queue that holds one.
    `HEC_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")

    // The rest of an entity or sequence always follows a byte in the output register.
    `HEC_ASSERT_IMPL(a_seq_behind_out, stat.seq_n != 3'd0, o_out_valid, "sequence without output")

    // A terminator leaves the string state cleared for the next string.
    `HEC_ASSERT_IMPL(a_final_clears, o_out_valid && o_final_res,
        !stat.ovf && stat.wn == 3'd0 && !stat.act, "string state not cleared at terminator")

endmodule
